// ===== rtl/lcsb_pkg.sv =====
// Shared package for the link connection supervisor.
// Holds state and request codes, register indexes, reset values and the
// structs passed between the modules. No dependencies.
`default_nettype none

package lcsb_pkg;

  // Default width of the internal time arithmetic
  localparam int unsigned TIME_BITS_DEF = 32;

  // Link state codes
  localparam logic [2:0] ST_DISABLED     = 3'd0;
  localparam logic [2:0] ST_IDLE         = 3'd1;
  localparam logic [2:0] ST_CONNECTING   = 3'd2;
  localparam logic [2:0] ST_CONNECTED    = 3'd3;
  localparam logic [2:0] ST_RECONNECTING = 3'd4;
  localparam logic [2:0] ST_FAILED       = 3'd5;

  // Request codes
  localparam logic [1:0] REQ_POLL  = 2'd0;
  localparam logic [1:0] REQ_BEGIN = 2'd1;
  localparam logic [1:0] REQ_END   = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_RADIO_ENABLE  = 3'd0;
  localparam logic [2:0] REG_NETWORK_CFG   = 3'd1;
  localparam logic [2:0] REG_CONN_TIMEOUT  = 3'd2;
  localparam logic [2:0] REG_BACKOFF_INIT  = 3'd3;
  localparam logic [2:0] REG_BACKOFF_MAX   = 3'd4;

  // Reset values
  localparam logic [31:0] CONN_TIMEOUT_RST = 32'd15000;
  localparam logic [31:0] BACKOFF_INIT_RST = 32'd1000;
  localparam logic [31:0] BACKOFF_MAX_RST  = 32'd60000;

  // Configuration seen by the core
  typedef struct packed {
    logic        radio_enable;
    logic        network_configured;
    logic [31:0] connect_timeout_ms;
    logic [31:0] backoff_initial_ms;
    logic [31:0] backoff_max_ms;
  } cfg_t;

  // One input word
  typedef struct packed {
    logic [1:0]         req_type;
    logic [31:0]        now_ms;
    logic               link_up;
    logic signed [7:0]  signal_dbm;
  } item_t;

  // One result word
  typedef struct packed {
    logic [2:0]         link_state;
    logic               start_attempt;
    logic               drop_link;
    logic               radio_off;
    logic [31:0]        connect_count;
    logic [31:0]        failure_count;
    logic [31:0]        disconnect_count;
    logic signed [7:0]  signal_report;
    logic [31:0]        connected_at_ms;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/link_connect_supervisor_backoff.sv =====
// Top level of the link connection supervisor with retry backoff.
// Depends on lcsb_pkg, lcsb_cfg and lcsb_core.
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+-----------------------------------
//  in       | input     | in_valid_i/in_stall_o  | req_type, now_ms, link_up, signal_dbm
//  out      | output    | out_valid_o/out_stall_i| link_state .. connected_at_ms
//  cfg      | input     | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// One word per cycle sustained while the output is not stalled. A word is
// registered on accept, stepped through the core logic once the result
// register is free or being taken, and lands in the result register, which
// offers it. The input register frees up whenever the result register is
// empty or being taken, so a stalled output holds back only one word in each
// register. Reset clears state and all valid flags at once.
`default_nettype none

module link_connect_supervisor_backoff
  import lcsb_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         req_type_i,
  input  wire logic [31:0]        now_ms_i,
  input  wire logic               link_up_i,
  input  wire logic signed [7:0]  signal_dbm_i,
  // output channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              link_state_o,
  output logic                    start_attempt_o,
  output logic                    drop_link_o,
  output logic                    radio_off_o,
  output logic [31:0]             connect_count_o,
  output logic [31:0]             failure_count_o,
  output logic [31:0]             disconnect_count_o,
  output logic signed [7:0]       signal_report_o,
  output logic [31:0]             connected_at_ms_o,
  // configuration
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_wdata_i
);

  cfg_t  cfg;
  item_t item_q;
  logic  item_vld_q;
  res_t  res_d, res_q;
  logic  res_vld_q;
  logic  fire;
  logic  in_acc;

  // Step when a word is held and the result slot is free or draining
  assign fire       = item_vld_q & (~res_vld_q | ~out_stall_i);
  assign in_stall_o = item_vld_q & ~fire;
  assign in_acc     = in_valid_i & ~in_stall_o;

  lcsb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lcsb_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .cfg_i  (cfg),
    .item_i (item_q),
    .res_o  (res_d)
  );

  // Input register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_acc) begin
      item_vld_q <= 1'b1;
    end else if (fire) begin
      item_vld_q <= 1'b0;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.req_type   <= req_type_i;
      item_q.now_ms     <= now_ms_i;
      item_q.link_up    <= link_up_i;
      item_q.signal_dbm <= signal_dbm_i;
    end
  end

  // Result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (fire) begin
      res_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      res_vld_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = res_vld_q;
  assign link_state_o       = res_q.link_state;
  assign start_attempt_o    = res_q.start_attempt;
  assign drop_link_o        = res_q.drop_link;
  assign radio_off_o        = res_q.radio_off;
  assign connect_count_o    = res_q.connect_count;
  assign failure_count_o    = res_q.failure_count;
  assign disconnect_count_o = res_q.disconnect_count;
  assign signal_report_o    = res_q.signal_report;
  assign connected_at_ms_o  = res_q.connected_at_ms;

endmodule

`default_nettype wire

// ===== rtl/lcsb_cfg.sv =====
// Configuration register file of the link connection supervisor.
// Depends on lcsb_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module lcsb_cfg
  import lcsb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;

  // Plain write port; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radio_enable       <= 1'b1;
      cfg_q.network_configured <= 1'b1;
      cfg_q.connect_timeout_ms <= CONN_TIMEOUT_RST;
      cfg_q.backoff_initial_ms <= BACKOFF_INIT_RST;
      cfg_q.backoff_max_ms     <= BACKOFF_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RADIO_ENABLE: cfg_q.radio_enable       <= cfg_wdata_i[0];
        REG_NETWORK_CFG:  cfg_q.network_configured <= cfg_wdata_i[0];
        REG_CONN_TIMEOUT: cfg_q.connect_timeout_ms <= cfg_wdata_i;
        REG_BACKOFF_INIT: cfg_q.backoff_initial_ms <= cfg_wdata_i;
        REG_BACKOFF_MAX:  cfg_q.backoff_max_ms     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/lcsb_core.sv =====
// Supervisor state and single-pass step logic: one word in, one result out.
// Depends on lcsb_pkg for state codes, request codes and the structs.
`default_nettype none

module lcsb_core
  import lcsb_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  fire_i,
  input  wire cfg_t  cfg_i,
  input  wire item_t item_i,
  output res_t       res_o
);

  localparam int unsigned CmpW = (TIME_BITS > 32) ? TIME_BITS : 32;

  logic [2:0]           state_q, state_d;
  logic [TIME_BITS-1:0] entered_q, entered_d;
  logic [TIME_BITS-1:0] retry_q, retry_d;
  logic [31:0]          backoff_q, backoff_d;
  logic [31:0]          conn_cnt_q, conn_cnt_d;
  logic [31:0]          fail_cnt_q, fail_cnt_d;
  logic [31:0]          drop_cnt_q, drop_cnt_d;
  logic signed [7:0]    sig_q, sig_d;
  logic [31:0]          stamp_q, stamp_d;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] since_retry;
  logic [TIME_BITS-1:0] elapsed;
  logic                 retry_due;
  logic                 timed_out;
  logic [32:0]          backoff_dbl;
  logic                 start, drop, off;

  // Time arithmetic, modulo 2^TIME_BITS
  assign now_t       = TIME_BITS'(item_i.now_ms);
  assign since_retry = now_t - retry_q;
  assign retry_due   = ~since_retry[TIME_BITS-1];
  assign elapsed     = now_t - entered_q;
  assign timed_out   = CmpW'(elapsed) > CmpW'(cfg_i.connect_timeout_ms);
  assign backoff_dbl = {backoff_q, 1'b0};

  // Next state for the word in the input register
  always_comb begin
    state_d    = state_q;
    entered_d  = entered_q;
    retry_d    = retry_q;
    backoff_d  = backoff_q;
    conn_cnt_d = conn_cnt_q;
    fail_cnt_d = fail_cnt_q;
    drop_cnt_d = drop_cnt_q;
    sig_d      = sig_q;
    stamp_d    = stamp_q;
    start      = 1'b0;
    drop       = 1'b0;
    off        = 1'b0;
    case (item_i.req_type)
      REQ_BEGIN: begin
        conn_cnt_d = '0;
        fail_cnt_d = '0;
        drop_cnt_d = '0;
        sig_d      = '0;
        stamp_d    = '0;
        if (!cfg_i.radio_enable) begin
          // forced, entry time untouched
          state_d = ST_DISABLED;
        end else if (!cfg_i.network_configured) begin
          if (state_q != ST_FAILED) begin
            state_d   = ST_FAILED;
            entered_d = now_t;
          end
        end else begin
          // goes straight to connecting, always with a fresh entry time
          state_d   = ST_CONNECTING;
          entered_d = now_t;
          start     = 1'b1;
        end
      end
      REQ_END: begin
        drop = cfg_i.radio_enable;
        off  = cfg_i.radio_enable;
        if (state_q != ST_DISABLED) begin
          state_d   = ST_DISABLED;
          entered_d = now_t;
        end
      end
      REQ_POLL: begin
        if (cfg_i.radio_enable) begin
          case (state_q)
            ST_IDLE: begin
              if (retry_due) begin
                start     = 1'b1;
                state_d   = ST_CONNECTING;
                entered_d = now_t;
              end
            end
            ST_CONNECTING, ST_RECONNECTING: begin
              if (item_i.link_up) begin
                conn_cnt_d = conn_cnt_q + 32'd1;
                stamp_d    = 32'(now_t);
                backoff_d  = cfg_i.backoff_initial_ms;
                state_d    = ST_CONNECTED;
                entered_d  = now_t;
              end else if (timed_out) begin
                fail_cnt_d = fail_cnt_q + 32'd1;
                drop       = 1'b1;
                retry_d    = now_t + TIME_BITS'(backoff_q);
                backoff_d  = (backoff_dbl > {1'b0, cfg_i.backoff_max_ms}) ?
                             cfg_i.backoff_max_ms : backoff_dbl[31:0];
                state_d    = ST_IDLE;
                entered_d  = now_t;
              end
            end
            ST_CONNECTED: begin
              if (!item_i.link_up) begin
                drop_cnt_d = drop_cnt_q + 32'd1;
                drop       = 1'b1;
                start      = 1'b1;
                state_d    = ST_RECONNECTING;
                entered_d  = now_t;
              end else begin
                sig_d = item_i.signal_dbm;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Result word, values after the step
  always_comb begin
    res_o.link_state       = state_d;
    res_o.start_attempt    = start;
    res_o.drop_link        = drop;
    res_o.radio_off        = off;
    res_o.connect_count    = conn_cnt_d;
    res_o.failure_count    = fail_cnt_d;
    res_o.disconnect_count = drop_cnt_d;
    res_o.signal_report    = (state_d == ST_CONNECTED) ? sig_d : 8'sd0;
    res_o.connected_at_ms  = stamp_d;
  end

  // State registers, advanced once per processed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_DISABLED;
      entered_q  <= '0;
      retry_q    <= '0;
      backoff_q  <= BACKOFF_INIT_RST;
      conn_cnt_q <= '0;
      fail_cnt_q <= '0;
      drop_cnt_q <= '0;
      sig_q      <= '0;
      stamp_q    <= '0;
    end else if (fire_i) begin
      state_q    <= state_d;
      entered_q  <= entered_d;
      retry_q    <= retry_d;
      backoff_q  <= backoff_d;
      conn_cnt_q <= conn_cnt_d;
      fail_cnt_q <= fail_cnt_d;
      drop_cnt_q <= drop_cnt_d;
      sig_q      <= sig_d;
      stamp_q    <= stamp_d;
    end
  end

endmodule

`default_nettype wire
